// ===== src/sfs_pkg.sv =====
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfs_pkg;

   // sheet and timing limits
   localparam int MAX_FRAMES = 256;
   localparam int TIME_BITS  = 16;
   localparam int ACC_W      = TIME_BITS + 1;

   // field widths
   localparam int IDX_W   = 8;            // frame index
   localparam int START_W = 8;            // range_start
   localparam int END_W   = 9;            // range_end
   localparam int POS_W   = 9;            // list position
   localparam int LEN_W   = 10;           // list length, up to 2*MAX_FRAMES-1
   localparam int COLS_W  = 7;            // frames_per_row
   localparam int PIX_W   = 10;           // frame width / height
   localparam int X_W     = 16;
   localparam int Y_W     = 18;

   // divider: two quotient bits per cycle
   localparam int DIV_RADIX = 2;
   localparam int DIV_STEPS = IDX_W / DIV_RADIX;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // port widths
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 48;

   // register reset values
   localparam logic [TIME_BITS-1:0] PERIOD_RST = 16'd100;
   localparam logic [START_W-1:0]   START_RST  = 8'd0;
   localparam logic [END_W-1:0]     END_RST    = 9'd16;
   localparam logic [COLS_W-1:0]    COLS_RST   = 7'd4;
   localparam logic [PIX_W-1:0]     WIDTH_RST  = 10'd32;
   localparam logic [PIX_W-1:0]     HEIGHT_RST = 10'd32;

   typedef enum logic [2:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_STOP   = 3'd2,
      OP_PAUSE  = 3'd3,
      OP_RESUME = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      CSR_PERIOD   = 3'd0,
      CSR_START    = 3'd1,
      CSR_END      = 3'd2,
      CSR_PINGPONG = 3'd3,
      CSR_LOOP     = 3'd4,
      CSR_COLS     = 3'd5,
      CSR_WIDTH    = 3'd6,
      CSR_HEIGHT   = 3'd7
   } csr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_ADVANCE,
      ST_INDEX,
      ST_DIVIDE,
      ST_PRODUCT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic accum_en;
      logic advance_en;
      logic index_en;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } stat_type;

endpackage

`default_nettype wire

// ===== src/sfs_divider.sv =====
// Iterative restoring divider: frame index by column count, two bits a cycle.
// Depends on sfs_pkg.
`default_nettype none

module sfs_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [sfs_pkg::IDX_W-1:0]   dividend,
   input  logic [sfs_pkg::COLS_W-1:0]  divisor,
   output logic                        done,
   output logic [sfs_pkg::IDX_W-1:0]   quotient,
   output logic [sfs_pkg::COLS_W-1:0]  remainder
);
   import sfs_pkg::*;

   logic                 busy_ff, busy_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]     quot_ff, quot_in;
   logic [COLS_W-1:0]    rem_ff, rem_in;
   logic [COLS_W-1:0]    div_ff, div_in;

   logic [IDX_W-1:0]     q_step;
   logic [COLS_W-1:0]    r_step;
   logic [COLS_W:0]      trial;

   // DIV_RADIX shift/subtract iterations per cycle
   always_comb begin
      r_step = rem_ff;
      q_step = quot_ff;
      trial  = '0;
      for (int i = 0; i < DIV_RADIX; i++) begin
         trial  = {r_step, q_step[IDX_W-1]};
         q_step = {q_step[IDX_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            trial     = trial - {1'b0, div_ff};
            q_step[0] = 1'b1;
         end
         r_step = trial[COLS_W-1:0];
      end
   end

   assign done = busy_ff && (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + 1'b1;
         quot_in = q_step;
         rem_in  = r_step;
         if (done) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== src/sfs_datapath.sv =====
// Datapath: config registers, play state, list arithmetic, divider and
// pixel multipliers. Depends on sfs_pkg and sfs_divider.
`default_nettype none

module sfs_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  sfs_pkg::cmd_type                  cmd,
   output sfs_pkg::stat_type                 stat,
   input  logic [sfs_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] elapsed
   input  logic [sfs_pkg::REQ_USER_W-1:0]    req_tuser,   // [2:0] op
   output logic [sfs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sfs_pkg::*;

   // config
   logic [TIME_BITS-1:0] period_ff, period_in;
   logic [START_W-1:0]   start_ff, start_in;
   logic [END_W-1:0]     end_ff, end_in;
   logic                 pingpong_ff, pingpong_in;
   logic                 loop_ff, loop_in;
   logic [COLS_W-1:0]    cols_ff, cols_in;
   logic [PIX_W-1:0]     fw_ff, fw_in;
   logic [PIX_W-1:0]     fh_ff, fh_in;

   // play state
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [ACC_W-1:0]     accum_ff, accum_in;
   logic                 playing_ff, playing_in;
   logic                 done_ff, done_in;

   // per-word payload
   logic [2:0]            op_ff;
   logic [TIME_BITS-1:0]  elapsed_ff;
   logic [POS_W-1:0]      n_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [IDX_W-1:0]      out_idx_ff;
   logic [X_W-1:0]        out_x_ff;
   logic [Y_W-1:0]        out_y_ff;
   logic                  out_playing_ff;
   logic                  out_done_ff;

   logic [END_W-1:0]     end_sat;
   logic [POS_W-1:0]     n_comb;
   logic [LEN_W-1:0]     n_dbl;
   logic [LEN_W-1:0]     len_raw;
   logic [LEN_W-1:0]     len_comb;
   logic [ACC_W:0]       acc_sum;
   logic [ACC_W-1:0]     acc_sat;
   logic                 adv_fire;
   logic [LEN_W-1:0]     pos_next;
   logic [LEN_W-1:0]     pos_clip;
   logic [LEN_W-1:0]     fwd_idx;
   logic [LEN_W:0]       back_idx;
   logic [IDX_W-1:0]     idx_comb;
   logic [COLS_W-1:0]    cols_eff;
   logic [IDX_W-1:0]     div_quot;
   logic [COLS_W-1:0]    div_rem;
   logic [COLS_W+PIX_W-1:0] x_full;
   logic [IDX_W+PIX_W-1:0]  y_full;

   assign csr_ready = 1'b1;

   // play list geometry; range_start always fits below MAX_FRAMES
   always_comb begin
      end_sat  = (end_ff > END_W'(MAX_FRAMES)) ? END_W'(MAX_FRAMES) : end_ff;
      n_comb   = (end_sat > {1'b0, start_ff}) ? (end_sat - {1'b0, start_ff}) : POS_W'(1);
      n_dbl    = {n_comb, 1'b0};
      if (!pingpong_ff) begin
         len_raw = {1'b0, n_comb};
      end else if (loop_ff) begin
         len_raw = n_dbl - LEN_W'(2);
      end else begin
         len_raw = n_dbl - LEN_W'(1);
      end
      len_comb = (len_raw == '0) ? LEN_W'(1) : len_raw;
   end

   // saturating accumulate
   assign acc_sum = {1'b0, accum_ff} + (ACC_W+1)'(elapsed_ff);
   assign acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];

   assign adv_fire = cmd.advance_en && (op_ff == OP_TICK) && playing_ff &&
                     (accum_ff >= ACC_W'(period_ff));
   assign pos_next = {1'b0, pos_ff} + LEN_W'(1);

   // list position to sheet index; positions past the list read as the last entry
   always_comb begin
      pos_clip = ({1'b0, pos_ff} >= len_ff) ? (len_ff - LEN_W'(1)) : {1'b0, pos_ff};
      fwd_idx  = LEN_W'(start_ff) + pos_clip;
      back_idx = (LEN_W+1)'(start_ff) + (LEN_W+1)'({n_ff, 1'b0}) - (LEN_W+1)'(2)
                 - (LEN_W+1)'(pos_clip);
      idx_comb = (pos_clip < LEN_W'(n_ff)) ? fwd_idx[IDX_W-1:0] : back_idx[IDX_W-1:0];
   end

   assign cols_eff = (cols_ff == '0) ? COLS_W'(1) : cols_ff;

   sfs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.index_en),
      .dividend  (idx_comb),
      .divisor   (cols_eff),
      .done      (stat.div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   assign x_full = div_rem * fw_ff;
   assign y_full = div_quot * fh_ff;

   // config writes
   always_comb begin
      period_in   = period_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      pingpong_in = pingpong_ff;
      loop_in     = loop_ff;
      cols_in     = cols_ff;
      fw_in       = fw_ff;
      fh_in       = fh_ff;
      if (csr_valid) begin
         case (csr_type'(csr_index))
            CSR_PERIOD:   period_in   = csr_data[TIME_BITS-1:0];
            CSR_START:    start_in    = csr_data[START_W-1:0];
            CSR_END:      end_in      = csr_data[END_W-1:0];
            CSR_PINGPONG: pingpong_in = csr_data[0];
            CSR_LOOP:     loop_in     = csr_data[0];
            CSR_COLS:     cols_in     = csr_data[COLS_W-1:0];
            CSR_WIDTH:    fw_in       = csr_data[PIX_W-1:0];
            CSR_HEIGHT:   fh_in       = csr_data[PIX_W-1:0];
            default: ;
         endcase
      end
   end

   // play state update: commands and accumulate, then advance
   always_comb begin
      pos_in     = pos_ff;
      accum_in   = accum_ff;
      playing_in = playing_ff;
      done_in    = done_ff;
      if (cmd.accum_en) begin
         case (op_ff)
            OP_TICK: begin
               if (playing_ff) begin
                  accum_in = acc_sat;
               end
            end
            OP_START: begin
               playing_in = 1'b1;
               pos_in     = '0;
               done_in    = 1'b0;
            end
            OP_STOP: begin
               playing_in = 1'b0;
               pos_in     = '0;
               done_in    = 1'b0;
            end
            OP_PAUSE: begin
               playing_in = 1'b0;
            end
            OP_RESUME: begin
               playing_in = 1'b1;
               done_in    = 1'b0;
            end
            default: ;
         endcase
      end
      if (adv_fire) begin
         accum_in = accum_ff - ACC_W'(period_ff);
         if (pos_next >= len_ff) begin
            if (loop_ff) begin
               pos_in = '0;
            end else begin
               pos_in     = POS_W'(len_ff - LEN_W'(1));
               playing_in = 1'b0;
               done_in    = 1'b1;
            end
         end else begin
            pos_in = pos_next[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RST;
         start_ff    <= START_RST;
         end_ff      <= END_RST;
         pingpong_ff <= 1'b0;
         loop_ff     <= 1'b0;
         cols_ff     <= COLS_RST;
         fw_ff       <= WIDTH_RST;
         fh_ff       <= HEIGHT_RST;
         pos_ff      <= '0;
         accum_ff    <= '0;
         playing_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         period_ff   <= period_in;
         start_ff    <= start_in;
         end_ff      <= end_in;
         pingpong_ff <= pingpong_in;
         loop_ff     <= loop_in;
         cols_ff     <= cols_in;
         fw_ff       <= fw_in;
         fh_ff       <= fh_in;
         pos_ff      <= pos_in;
         accum_ff    <= accum_in;
         playing_ff  <= playing_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff      <= req_tuser;
         elapsed_ff <= req_tdata[TIME_BITS-1:0];
      end
      if (cmd.accum_en) begin
         n_ff   <= n_comb;
         len_ff <= len_comb;
      end
      if (cmd.index_en) begin
         idx_ff <= idx_comb;
      end
      if (cmd.out_load) begin
         out_idx_ff     <= idx_ff;
         out_x_ff       <= x_full[X_W-1:0];
         out_y_ff       <= y_full[Y_W-1:0];
         out_playing_ff <= playing_ff;
         out_done_ff    <= done_ff;
      end
   end

   assign rsp_tdata = {4'b0, out_done_ff, out_playing_ff, out_y_ff, out_x_ff, out_idx_ff};

`ifndef SYNTH
   a_done_not_playing: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !playing_ff)
      else $error("finished and playing both set");

   a_advance_in_list: assert property (@(posedge clock) disable iff (reset)
      adv_fire |=> ({1'b0, pos_ff} < len_ff))
      else $error("advance left position outside play list");

   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      stat.div_done |=> (div_rem < cols_eff))
      else $error("column remainder not below column count");
`endif

endmodule

`default_nettype wire

// ===== src/sfs_ctrl.sv =====
// Controller state machine: sequences one command word through the datapath.
// Depends on sfs_pkg.
`default_nettype none

module sfs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output sfs_pkg::cmd_type   cmd,
   input  sfs_pkg::stat_type  stat
);
   import sfs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            cmd.accum_en = 1'b1;
            state_in     = ST_ADVANCE;
         end
         ST_ADVANCE: begin
            cmd.advance_en = 1'b1;
            state_in       = ST_INDEX;
         end
         ST_INDEX: begin
            cmd.index_en = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (stat.div_done) begin
               state_in = ST_PRODUCT;
            end
         end
         ST_PRODUCT: begin
            // output register must be free or draining this cycle
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef SYNTH
   a_cmd_exclusive: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load_req, cmd.accum_en, cmd.advance_en, cmd.index_en, cmd.out_load}))
      else $error("more than one datapath command at once");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_ACCUM))
      else $error("accepted word did not start processing");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRODUCT && rsp_valid_ff && !rsp_tready)
      |=> (state_ff == ST_PRODUCT && rsp_valid_ff))
      else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/sprite_frame_sequencer_unit.sv =====
// Sprite frame sequencer: one result word per command word.
// Steps: accumulate, advance, index, column divider at 2 bits/cycle, multiply,
// then the result register; one word is in the steps at a time.
// A new request is taken once the previous word has reached the result register,
// while that result still waits on rsp_tready.
// Reset: synchronous, active high; registers to defaults, stopped, position 0.
`default_nettype none

module sprite_frame_sequencer_unit (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sfs_pkg::REQ_DATA_W-1:0]    req_tdata,   // [15:0] elapsed
   input  logic [sfs_pkg::REQ_USER_W-1:0]    req_tuser,   // [2:0] op
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [7:0] frame_index, [23:8] frame_x, [41:24] frame_y,
   // [42] playing, [43] finished, [47:44] zero
   output logic [sfs_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sfs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sfs_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sfs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing of each word
   sfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // registers, play state, divide and multiply
   sfs_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for sprite_frame_sequencer_unit: streams command words,
// predicts each response word in place and compares it field by field.
// Depends on sfs_pkg (op and register codes, widths) and the RTL under src/.
`timescale 1ns / 1ps

module testbench;
   import sfs_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int DRAIN_CYCLES = 12;      // extra settle time after the last expected word
   localparam int PRINT_CAP = 60;
   localparam int ACC_MAX = (1 << ACC_W) - 1;

   // op codes the block does not decode; they only report the current frame
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   // response word, lowest field last
   typedef struct packed {
      logic [3:0]  spare;
      logic        finished;
      logic        playing;
      logic [17:0] pix_y;
      logic [15:0] pix_x;
      logic [7:0]  frame_idx;
   } frame_word;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;   // [15:0] elapsed
   logic [REQ_USER_W-1:0]   req_tuser = '0;   // [2:0] op
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;        // idx, x, y, playing, finished
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index = '0;
   logic [CSR_DATA_W-1:0]   csr_data = '0;

   sprite_frame_sequencer_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Sequencer shadow: register copies and playback state
   // ---------------------------------------------------------------------
   logic [15:0] cfg_period;
   logic [7:0]  cfg_start;
   logic [8:0]  cfg_end;
   logic        cfg_pingpong;
   logic        cfg_loop;
   logic [6:0]  cfg_cols;
   logic [9:0]  cfg_width;
   logic [9:0]  cfg_height;

   int unsigned seq_pos;
   int unsigned seq_accum;
   bit          seq_playing;
   bit          seq_done;

   frame_word frames_due[$];   // predicted response words, oldest first
   int mismatch_count = 0;
   int cycle_count = 0;

   // pacing knobs for the sender and the response sink
   bit src_jitter = 1'b0;
   bit sink_jitter = 1'b0;
   int sink_hold = 0;          // long hold-off, counted down by the sink

   function automatic void reset_shadow();
      cfg_period   = PERIOD_RST;
      cfg_start    = START_RST;
      cfg_end      = END_RST;
      cfg_pingpong = 1'b0;
      cfg_loop     = 1'b0;
      cfg_cols     = COLS_RST;
      cfg_width    = WIDTH_RST;
      cfg_height   = HEIGHT_RST;
      seq_pos      = 0;
      seq_accum    = 0;
      seq_playing  = 1'b0;
      seq_done     = 1'b0;
   endfunction

   function automatic void store_reg(csr_type which, logic [15:0] value);
      case (which)
         CSR_PERIOD:   cfg_period   = value;
         CSR_START:    cfg_start    = value[7:0];
         CSR_END:      cfg_end      = value[8:0];
         CSR_PINGPONG: cfg_pingpong = value[0];
         CSR_LOOP:     cfg_loop     = value[0];
         CSR_COLS:     cfg_cols     = value[6:0];
         CSR_WIDTH:    cfg_width    = value[9:0];
         CSR_HEIGHT:   cfg_height   = value[9:0];
         default: ;
      endcase
   endfunction

   // first frame, clamped to the sheet
   function automatic int unsigned range_first();
      return (cfg_start > MAX_FRAMES - 1) ? MAX_FRAMES - 1 : cfg_start;
   endfunction

   // frames in the range; an empty range plays one frame
   function automatic int unsigned range_frames();
      int unsigned s, e;
      s = range_first();
      e = (cfg_end > MAX_FRAMES) ? MAX_FRAMES : cfg_end;
      return (e > s) ? e - s : 1;
   endfunction

   // entries in the play list, counting the return leg of ping-pong
   function automatic int unsigned list_entries();
      int unsigned n, len;
      n = range_frames();
      if (!cfg_pingpong)
         len = n;
      else if (cfg_loop)
         len = 2 * n - 2;
      else
         len = 2 * n - 1;
      return (len == 0) ? 1 : len;
   endfunction

   // sheet index of the current entry; a stale position reads as the last one
   function automatic int unsigned sheet_index();
      int unsigned n, len, p;
      n = range_frames();
      len = list_entries();
      p = (seq_pos >= len) ? len - 1 : seq_pos;
      if (p < n)
         return range_first() + p;
      return range_first() + (2 * n - 2 - p);
   endfunction

   function automatic void advance_clock(logic [15:0] elapsed);
      int unsigned sum, len;
      if (!seq_playing)
         return;
      sum = seq_accum + elapsed;
      if (sum > ACC_MAX)
         sum = ACC_MAX;
      if (sum < cfg_period) begin
         seq_accum = sum;
         return;
      end
      seq_accum = sum - cfg_period;
      len = list_entries();
      if (seq_pos + 1 >= len) begin
         if (cfg_loop) begin
            seq_pos = 0;
         end else begin
            seq_pos = len - 1;
            seq_playing = 1'b0;
            seq_done = 1'b1;
         end
      end else begin
         seq_pos++;
      end
   endfunction

   // apply one command to the shadow and return the word it must produce
   function automatic frame_word predict_frame(logic [2:0] op, logic [15:0] elapsed);
      frame_word w;
      int unsigned idx, cols;
      case (op)
         OP_TICK:   advance_clock(elapsed);
         OP_START:  begin seq_playing = 1'b1; seq_pos = 0; seq_done = 1'b0; end
         OP_STOP:   begin seq_playing = 1'b0; seq_pos = 0; seq_done = 1'b0; end
         OP_PAUSE:  seq_playing = 1'b0;
         OP_RESUME: begin seq_playing = 1'b1; seq_done = 1'b0; end
         default: ;
      endcase
      idx = sheet_index();
      cols = (cfg_cols == 0) ? 1 : cfg_cols;
      w = '0;
      w.frame_idx = idx[7:0];
      w.pix_x     = 16'((idx % cols) * cfg_width);
      w.pix_y     = 18'((idx / cols) * cfg_height);
      w.playing   = seq_playing;
      w.finished  = seq_done;
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // Random helpers
   // ---------------------------------------------------------------------
   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // elapsed time biased around the frame period so advances happen often
   function automatic logic [15:0] pick_elapsed();
      int unsigned r, span;
      r = $urandom_range(0, 99);
      span = (cfg_period == 0) ? 4 : 2 * cfg_period;
      if (span > 16'hFFFF) span = 16'hFFFF;
      if (r < 55) return 16'($urandom_range(0, span));
      if (r < 70) return cfg_period;
      if (r < 82) return 16'($urandom_range(0, 3));
      if (r < 90) return 16'hFFFF;
      return 16'($urandom_range(0, 16'hFFFF));
   endfunction

   // mostly ticks; control commands and undecoded codes mixed in
   function automatic logic [2:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 74) return OP_TICK;
      if (r < 79) return OP_START;
      if (r < 83) return OP_STOP;
      if (r < 89) return OP_PAUSE;
      if (r < 95) return OP_RESUME;
      case ($urandom_range(0, 2))
         0:       return OP_SPARE_A;
         1:       return OP_SPARE_B;
         default: return OP_SPARE_C;
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Driving tasks: inputs change on the falling edge, sampled on the rising
   // ---------------------------------------------------------------------
   task automatic send_cmd(logic [2:0] op, logic [15:0] elapsed);
      int gap;
      gap = src_jitter ? pick_gap() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= elapsed;
      do @(posedge clock); while (req_tready !== 1'b1);
      frames_due.insert(frames_due.size(), predict_frame(op, elapsed));
   endtask

   task automatic write_reg(csr_type which, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      store_reg(which, value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // stop offering words and wait until every predicted word came back
   task automatic wait_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_setup(int unsigned period, int unsigned first, int unsigned last,
                             bit pingpong, bit wrap, int unsigned cols,
                             int unsigned width, int unsigned height);
      write_reg(CSR_PERIOD, 16'(period));
      write_reg(CSR_START, 16'(first));
      write_reg(CSR_END, 16'(last));
      write_reg(CSR_PINGPONG, 16'(pingpong));
      write_reg(CSR_LOOP, 16'(wrap));
      write_reg(CSR_COLS, 16'(cols));
      write_reg(CSR_WIDTH, 16'(width));
      write_reg(CSR_HEIGHT, 16'(height));
   endtask

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------
   task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] %s: got %0h, want %0h", $time, what, got, want);
   endtask

   always @(posedge clock) begin : check_words
      frame_word got, want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         got = frame_word'(rsp_tdata);
         if (frames_due.size() == 0) begin
            report_mismatch("unexpected response word", 64'(got), 64'd0);
         end else begin
            want = frames_due.pop_front();
            if (got.frame_idx !== want.frame_idx)
               report_mismatch("frame_index", 64'(got.frame_idx), 64'(want.frame_idx));
            if (got.pix_x !== want.pix_x)
               report_mismatch("frame_x", 64'(got.pix_x), 64'(want.pix_x));
            if (got.pix_y !== want.pix_y)
               report_mismatch("frame_y", 64'(got.pix_y), 64'(want.pix_y));
            if (got.playing !== want.playing)
               report_mismatch("playing", 64'(got.playing), 64'(want.playing));
            if (got.finished !== want.finished)
               report_mismatch("finished", 64'(got.finished), 64'(want.finished));
            if (got.spare !== want.spare)
               report_mismatch("pad bits", 64'(got.spare), 64'(want.spare));
         end
      end
   end

   // Response sink: random stalls, or a long hold-off when a test asks for one.
   initial begin : sink_pacing
      int gap;
      gap = 0;
      forever begin
         @(negedge clock);
         if (sink_hold > 0) begin
            sink_hold--;
            rsp_tready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (sink_jitter && $urandom_range(0, 3) == 0)
               gap = pick_gap();
         end
      end
   end

   // Watchdog: a hang or lost word ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Default registers: every command, idle ticks, elapsed extremes.
   task automatic test_commands();
      send_cmd(OP_TICK, 16'd50);       // stopped, nothing moves
      send_cmd(OP_START, 16'hFFFF);    // elapsed ignored by non-ticks
      send_cmd(OP_TICK, 16'd99);
      send_cmd(OP_TICK, 16'd1);        // period reached, one advance
      send_cmd(OP_TICK, 16'hFFFF);     // large step still advances once
      send_cmd(OP_PAUSE, 16'd0);
      send_cmd(OP_TICK, 16'd10);
      send_cmd(OP_RESUME, 16'd0);
      send_cmd(OP_STOP, 16'd0);
      send_cmd(OP_SPARE_A, 16'd0);
      send_cmd(OP_SPARE_C, 16'hFFFF);
      wait_drain();
   endtask

   // Non-looping list end, ticks after finish, resume restarts on last entry.
   task automatic test_list_end();
      load_setup(1, 10, 12, 1'b0, 1'b0, 5, 7, 3);
      send_cmd(OP_START, 16'd0);
      send_cmd(OP_TICK, 16'd1);
      send_cmd(OP_TICK, 16'd1);        // list end: stop and raise finished
      send_cmd(OP_TICK, 16'd1);
      send_cmd(OP_RESUME, 16'd0);
      send_cmd(OP_TICK, 16'd1);        // next advance ends the list again
      wait_drain();
   endtask

   // Zero period, saturating accumulator, empty range, one-entry ping-pong
   // loop, zero columns, then a range running off the sheet.
   task automatic test_corner_setups();
      load_setup(0, 9, 5, 1'b1, 1'b1, 0, 1023, 1023);
      send_cmd(OP_START, 16'd0);
      send_cmd(OP_TICK, 16'hFFFF);
      send_cmd(OP_TICK, 16'hFFFF);
      send_cmd(OP_TICK, 16'hFFFF);     // accumulator pinned at all ones
      wait_drain();
      load_setup(16'hFFFF, 250, 511, 1'b1, 1'b0, 64, 1023, 1);
      send_cmd(OP_TICK, 16'd0);        // saturated remainder still advances
      send_cmd(OP_TICK, 16'd0);
      wait_drain();
   endtask

   // Shrinking the range under a running position.
   task automatic test_shrunk_range();
      load_setup(1, 0, 16, 1'b0, 1'b0, 4, 32, 32);
      send_cmd(OP_START, 16'd0);
      repeat (3) send_cmd(OP_TICK, 16'd1);
      wait_drain();
      write_reg(CSR_END, 2);           // position now past the list
      send_cmd(OP_SPARE_B, 16'd0);
      send_cmd(OP_TICK, 16'd1);        // advance from there ends the list
      wait_drain();
   endtask

   // Sink holds off for a long stretch while commands keep coming, so the
   // block fills and back-pressures the request side.
   task automatic test_output_stall();
      load_setup(3, 4, 9, 1'b1, 1'b1, 3, 17, 9);
      src_jitter = 1'b0;
      sink_hold = 400;
      send_cmd(OP_START, 16'd0);
      repeat (20) send_cmd(OP_TICK, pick_elapsed());
      wait_drain();
   endtask

   task automatic random_setup(int kind);
      int unsigned r, period, first, last, cols;
      case (kind)
         0: load_setup(0, 0, 0, 1'b1, 1'b1, 0, 0, 0);
         1: load_setup(16'hFFFF, 255, 511, 1'b1, 1'b0, 127, 1023, 1023);
         2: load_setup(1, 0, 256, 1'b0, 1'b1, 64, 1023, 1023);   // whole sheet
         default: begin
            r = $urandom_range(0, 99);
            if (r < 40)      period = $urandom_range(1, 20);
            else if (r < 60) period = $urandom_range(20, 300);
            else if (r < 70) period = 0;
            else if (r < 78) period = 16'hFFFF;
            else             period = $urandom_range(0, 16'hFFFF);
            first = $urandom_range(0, 255);
            r = $urandom_range(0, 99);
            if (r < 75)      last = first + $urandom_range(1, 8);
            else if (r < 85) last = $urandom_range(0, first);
            else             last = $urandom_range(0, 511);
            r = $urandom_range(0, 99);
            if (r < 70)      cols = $urandom_range(1, 64);
            else if (r < 80) cols = 0;
            else             cols = $urandom_range(65, 127);
            load_setup(period, first, last,
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       cols, $urandom_range(0, 1023), $urandom_range(0, 1023));
         end
      endcase
   endtask

   // Random phases: a fresh register set per phase, then a mostly
   // well-formed command stream (start, then ticks with control mixed in).
   task automatic test_random_play(int phases);
      int count;
      for (int ph = 0; ph < phases; ph++) begin
         random_setup(ph);
         src_jitter  = (ph % 3) != 1;
         sink_jitter = (ph % 4) != 2;
         count = (ph == 2) ? 300 : (ph < 2) ? 80 : $urandom_range(60, 120);
         if ($urandom_range(0, 9) < 8)
            send_cmd(OP_START, 16'($urandom_range(0, 16'hFFFF)));
         for (int k = 0; k < count; k++) begin
            send_cmd(pick_op(), pick_elapsed());
            if ($urandom_range(0, 79) == 0)
               wait_drain();
         end
         wait_drain();
      end
   endtask

   initial begin
      reset_shadow();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_commands();
      test_list_end();
      test_corner_setups();
      test_shrunk_range();
      test_output_stall();
      test_random_play(15);

      wait_drain();
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
